// ===== hw/rtl/dprt_pkg.sv =====
// Shared widths, constants, codes and control/status types of the dosing pump run timer.
package dprt_pkg;

	localparam int unsigned FUNC_W     = 2;
	localparam int unsigned VOL_W      = 24;
	localparam int unsigned MS_W       = 24;
	localparam int unsigned FLOW_W     = 20;
	localparam int unsigned SEC_W      = 15;
	localparam int unsigned SUBMS_W    = 10;
	localparam int unsigned PROD_W     = MS_W + FLOW_W;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = FLOW_W;

	localparam logic [MS_W-1:0]    MAX_RUN_MS  = MS_W'(600000);
	localparam logic [MS_W-1:0]    MIN_DOSE_MS = MS_W'(200);
	localparam logic [MS_W-1:0]    MS_SAT      = {MS_W{1'b1}};
	localparam logic [VOL_W-1:0]   VOL_SAT     = {VOL_W{1'b1}};
	localparam logic [FLOW_W-1:0]  MS_PER_S    = FLOW_W'(1000);
	localparam logic [SUBMS_W-1:0] SUBMS_LAST  = SUBMS_W'(999);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_DOSE  = 2'd1,
		FUNC_TIMED = 2'd2,
		FUNC_STOP  = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FLOW_RATE         = 1'b0,
		REG_RELAY_ACTIVE_HIGH = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_DOSE  = 2'd0,
		OP_TIMED = 2'd1,
		OP_LIVE  = 2'd2
	} op_t;

	typedef struct packed {
		logic load;
		logic tick;
		logic mul;
		logic div_start;
		logic begin_run;
		logic live;
		logic halt;
		logic out_load;
		logic accepted;
		logic finished;
		op_t  op;
	} dprt_cmd_t;

	typedef struct packed {
		func_t func;
		logic  running;
		logic  dv_zero;
		logic  rd_zero;
		logic  flow_zero;
		logic  reached;
		logic  div_done;
	} dprt_sts_t;

endpackage

// ===== hw/rtl/dprt_if.sv =====
// Command and result channel interfaces of the dosing pump run timer.
interface dprt_in_if
	import dprt_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [VOL_W-1:0]  dose_volume;
	logic [MS_W-1:0]   run_duration;

	modport source (output valid, output func, output dose_volume, output run_duration,
		input ready);
	modport sink (input valid, input func, input dose_volume, input run_duration,
		output ready);
endinterface

interface dprt_out_if
	import dprt_pkg::*;
;
	logic             valid;
	logic             ready;
	logic             relay_level;
	logic             pump_running;
	logic             start_accepted;
	logic             run_finished;
	logic [VOL_W-1:0] volume_done;
	logic [SEC_W-1:0] run_seconds;

	modport source (output valid, output relay_level, output pump_running,
		output start_accepted, output run_finished, output volume_done, output run_seconds,
		input ready);
	modport sink (input valid, input relay_level, input pump_running,
		input start_accepted, input run_finished, input volume_done, input run_seconds,
		output ready);
endinterface

// ===== hw/rtl/dprt_div.sv =====
// Restoring divider, one quotient bit per cycle.
module dprt_div
	import dprt_pkg::*;
#(
	parameter int unsigned DVD_W = PROD_W,
	parameter int unsigned DSR_W = FLOW_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quot_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DSR_W:0]   rem_sh;
	logic [DSR_W:0]   rem_sub;
	logic             ge;

	always_comb begin
		rem_sh  = {rem_q, quot_q[DVD_W-1]};
		ge      = rem_sh >= {1'b0, dsr_q};
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[DVD_W-2:0], ge};
			rem_q  <= ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ===== hw/rtl/dprt_ctrl.sv =====
// Sequencing state machine of the dosing pump run timer.
module dprt_ctrl
	import dprt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  dprt_sts_t sts,
	output dprt_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_TCHK,
		S_MUL,
		S_DIVGO,
		S_DIVWAIT,
		S_FINISH,
		S_OUT
	} state_t;

	state_t state_q;
	op_t    op_q;
	logic   acc_q;
	logic   fin_q;
	logic   halt_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.op        = op_q;
		cmd.accepted  = acc_q;
		cmd.finished  = fin_q;
		cmd.halt      = halt_q;
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.tick      = (state_q == S_EXEC) && (sts.func == FUNC_TICK) && sts.running;
		cmd.mul       = (state_q == S_MUL);
		cmd.div_start = (state_q == S_DIVGO);
		cmd.begin_run = (state_q == S_FINISH) && (op_q != OP_LIVE);
		cmd.live      = (state_q == S_FINISH) && (op_q == OP_LIVE);
		cmd.out_load  = (state_q == S_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_LIVE;
			acc_q       <= 1'b0;
			fin_q       <= 1'b0;
			halt_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						acc_q   <= 1'b0;
						fin_q   <= 1'b0;
						halt_q  <= 1'b0;
						op_q    <= OP_LIVE;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (sts.func)
						FUNC_TICK: begin
							state_q <= sts.running ? S_TCHK : S_OUT;
						end
						FUNC_DOSE: begin
							if (!sts.running && !sts.dv_zero && !sts.flow_zero) begin
								op_q    <= OP_DOSE;
								state_q <= S_MUL;
							end else begin
								state_q <= sts.running ? S_MUL : S_OUT;
							end
						end
						FUNC_TIMED: begin
							if (!sts.running && !sts.rd_zero) begin
								op_q    <= OP_TIMED;
								state_q <= S_MUL;
							end else begin
								state_q <= sts.running ? S_MUL : S_OUT;
							end
						end
						FUNC_STOP: begin
							halt_q  <= sts.running;
							state_q <= sts.running ? S_MUL : S_OUT;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_TCHK: begin
					halt_q  <= sts.reached;
					fin_q   <= sts.reached;
					state_q <= S_MUL;
				end
				S_MUL:     state_q <= S_DIVGO;
				S_DIVGO:   state_q <= S_DIVWAIT;
				S_DIVWAIT: begin
					if (sts.div_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (op_q == OP_LIVE) begin
						state_q <= S_OUT;
					end else begin
						// new run: follow up with its live volume
						acc_q   <= 1'b1;
						op_q    <= OP_LIVE;
						state_q <= S_MUL;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/dprt_dp.sv =====
// Datapath: run state, configuration, shared multiplier and divider, result word.
module dprt_dp
	import dprt_pkg::*;
#(
	parameter logic [MS_W-1:0] RUN_MS_MAX  = MAX_RUN_MS,
	parameter logic [MS_W-1:0] DOSE_MS_MIN = MIN_DOSE_MS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dprt_cmd_t             cmd,
	output dprt_sts_t             sts,
	input  logic [FUNC_W-1:0]     in_func,
	input  logic [VOL_W-1:0]      in_dose_volume,
	input  logic [MS_W-1:0]       in_run_duration,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  relay_level,
	output logic                  pump_running,
	output logic                  start_accepted,
	output logic                  run_finished,
	output logic [VOL_W-1:0]      volume_done,
	output logic [SEC_W-1:0]      run_seconds
);

	logic [FLOW_W-1:0]  flow_q;
	logic               rah_q;
	func_t              func_q;
	logic [VOL_W-1:0]   dv_q;
	logic [MS_W-1:0]    rd_q;
	logic               running_q;
	logic [MS_W-1:0]    elapsed_q;
	logic [SUBMS_W-1:0] subms_q;
	logic [SEC_W-1:0]   secs_q;
	logic [MS_W-1:0]    target_ms_q;
	logic [VOL_W-1:0]   target_vol_q;
	logic [VOL_W-1:0]   delivered_q;
	logic [VOL_W-1:0]   live_q;
	logic [PROD_W-1:0]  prod_s1;

	logic               relay_q;
	logic               pump_running_q;
	logic               accepted_q;
	logic               finished_q;
	logic [VOL_W-1:0]   volume_q;
	logic [SEC_W-1:0]   seconds_q;

	logic [MS_W-1:0]    mul_a;
	logic [FLOW_W-1:0]  mul_b;
	logic [FLOW_W-1:0]  div_dsr;
	logic               div_done;
	logic [PROD_W-1:0]  quot;
	logic [PROD_W-1:0]  dose_lo;
	logic [MS_W-1:0]    dose_ms;
	logic [MS_W-1:0]    timed_ms;
	logic [VOL_W-1:0]   timed_vol;
	logic [VOL_W-1:0]   live_vol;

	always_comb begin
		unique case (cmd.op)
			OP_DOSE: begin
				mul_a   = dv_q;
				mul_b   = MS_PER_S;
				div_dsr = flow_q;
			end
			OP_TIMED: begin
				mul_a   = rd_q;
				mul_b   = flow_q;
				div_dsr = MS_PER_S;
			end
			default: begin
				mul_a   = (elapsed_q > target_ms_q) ? target_ms_q : elapsed_q;
				mul_b   = flow_q;
				div_dsr = MS_PER_S;
			end
		endcase
	end

	dprt_div #(
		.DVD_W(PROD_W),
		.DSR_W(FLOW_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(prod_s1),
		.divisor (div_dsr),
		.done    (div_done),
		.quotient(quot)
	);

	always_comb begin
		dose_lo   = (quot < PROD_W'(DOSE_MS_MIN)) ? PROD_W'(DOSE_MS_MIN) : quot;
		dose_ms   = (dose_lo > PROD_W'(RUN_MS_MAX)) ? RUN_MS_MAX : dose_lo[MS_W-1:0];
		timed_ms  = (rd_q > RUN_MS_MAX) ? RUN_MS_MAX : rd_q;
		timed_vol = (quot > PROD_W'(VOL_SAT)) ? VOL_SAT : quot[VOL_W-1:0];
		live_vol  = (quot > PROD_W'(target_vol_q)) ? target_vol_q : quot[VOL_W-1:0];
	end

	always_comb begin
		sts.func      = func_q;
		sts.running   = running_q;
		sts.dv_zero   = (dv_q == '0);
		sts.rd_zero   = (rd_q == '0);
		sts.flow_zero = (flow_q == '0);
		sts.reached   = (elapsed_q >= target_ms_q);
		sts.div_done  = div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_q       <= '0;
			rah_q        <= 1'b0;
			running_q    <= 1'b0;
			elapsed_q    <= '0;
			subms_q      <= '0;
			secs_q       <= '0;
			target_ms_q  <= '0;
			target_vol_q <= '0;
			delivered_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					REG_FLOW_RATE:         flow_q <= cfg_data;
					REG_RELAY_ACTIVE_HIGH: rah_q  <= cfg_data[0];
					default:               flow_q <= flow_q;
				endcase
			end
			if (cmd.tick && (elapsed_q != MS_SAT)) begin
				elapsed_q <= elapsed_q + MS_W'(1);
				if (subms_q == SUBMS_LAST) begin
					subms_q <= '0;
					secs_q  <= secs_q + SEC_W'(1);
				end else begin
					subms_q <= subms_q + SUBMS_W'(1);
				end
			end
			if (cmd.begin_run) begin
				target_ms_q  <= (cmd.op == OP_DOSE) ? dose_ms : timed_ms;
				target_vol_q <= (cmd.op == OP_DOSE) ? dv_q : timed_vol;
				delivered_q  <= '0;
				elapsed_q    <= '0;
				subms_q      <= '0;
				secs_q       <= '0;
				running_q    <= 1'b1;
			end
			if (cmd.live && cmd.halt) begin
				delivered_q <= live_vol;
				running_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(in_func);
			dv_q   <= in_dose_volume;
			rd_q   <= in_run_duration;
		end
		if (cmd.mul) begin
			prod_s1 <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
		if (cmd.live) begin
			live_q <= live_vol;
		end
		if (cmd.out_load) begin
			relay_q        <= running_q ? rah_q : !rah_q;
			pump_running_q <= running_q;
			accepted_q     <= cmd.accepted;
			finished_q     <= cmd.finished;
			volume_q       <= running_q ? live_q : delivered_q;
			seconds_q      <= running_q ? secs_q : '0;
		end
	end

	assign relay_level    = relay_q;
	assign pump_running   = pump_running_q;
	assign start_accepted = accepted_q;
	assign run_finished   = finished_q;
	assign volume_done    = volume_q;
	assign run_seconds    = seconds_q;

endmodule

// ===== hw/rtl/dosing_pump_run_timer.sv =====
// Top level of the dosing pump run timer: controller, datapath and channel hookup.
//
//   channel  dir  handshake      word
//   cmd      in   valid/ready    func, dose_volume, run_duration
//   rsp      out  valid/ready    relay_level, pump_running, start_accepted,
//                                run_finished, volume_done, run_seconds
//   cfg      in   cfg_we         cfg_index, cfg_data
//
// One command word at a time. An idle tick, or a rejected start or a stop with the pump off,
// goes straight to the result; any word with the pump running makes one multiply/divide pass;
// an accepted start makes two. The 44-step shared restoring divider runs once per product.
// arst_n clears the run flag, counters, targets, delivered volume and both registers to zero.
// rsp holds its word in an output register, so a new command is taken while it waits;
// that command stalls only at its last step until rsp is free.
module dosing_pump_run_timer
	import dprt_pkg::*;
#(
	parameter logic [MS_W-1:0] RUN_MS_MAX  = MAX_RUN_MS,
	parameter logic [MS_W-1:0] DOSE_MS_MIN = MIN_DOSE_MS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dprt_in_if.sink               cmd,
	dprt_out_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dprt_cmd_t ctl_cmd;
	dprt_sts_t dp_sts;
	logic      in_ready;
	logic      out_valid;

	dprt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(rsp.ready),
		.sts      (dp_sts),
		.cmd      (ctl_cmd)
	);

	dprt_dp #(
		.RUN_MS_MAX (RUN_MS_MAX),
		.DOSE_MS_MIN(DOSE_MS_MIN)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (ctl_cmd),
		.sts            (dp_sts),
		.in_func        (cmd.func),
		.in_dose_volume (cmd.dose_volume),
		.in_run_duration(cmd.run_duration),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.relay_level    (rsp.relay_level),
		.pump_running   (rsp.pump_running),
		.start_accepted (rsp.start_accepted),
		.run_finished   (rsp.run_finished),
		.volume_done    (rsp.volume_done),
		.run_seconds    (rsp.run_seconds)
	);

	assign cmd.ready = in_ready;
	assign rsp.valid = out_valid;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the dosing pump run timer: directed table, then random run sequences.
`timescale 1ns / 100ps

module testbench;
	import dprt_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1500000;
	localparam int unsigned PHASE_WORDS   = 140;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned TAIL_CYCLES   = 200;

	typedef struct packed {
		logic             relay_level;
		logic             pump_running;
		logic             start_accepted;
		logic             run_finished;
		logic [VOL_W-1:0] volume_done;
		logic [SEC_W-1:0] run_seconds;
	} pump_status_t;

	typedef enum logic {
		ROW_CMD = 1'b0,
		ROW_CFG = 1'b1
	} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		func_t                 func;
		logic [VOL_W-1:0]      dv;
		logic [MS_W-1:0]       rd;
		cfg_idx_t              idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  known;
		pump_status_t          want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dprt_in_if  cmd_if ();
	dprt_out_if rsp_if ();

	dosing_pump_run_timer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// pump state as the block should hold it
	logic              pm_running;
	logic [MS_W-1:0]   pm_elapsed;
	logic [MS_W-1:0]   pm_target_ms;
	logic [VOL_W-1:0]  pm_target_vol;
	logic [VOL_W-1:0]  pm_delivered;
	logic [FLOW_W-1:0] pm_flow;
	logic              pm_active_high;

	pump_status_t pending_status[$];
	plan_row_t    plan_rows[$];

	int unsigned mismatches    = 0;
	int unsigned words_sent    = 0;
	int unsigned starts_taken  = 0;
	int unsigned runs_ended    = 0;
	int unsigned settings_used = 0;
	int unsigned cycles        = 0;
	int unsigned src_idle_pct  = 19;
	int unsigned sink_idle_pct = 80;

	function automatic logic [VOL_W-1:0] live_volume();
		logic [63:0] el;
		logic [63:0] v;
		el = (pm_elapsed > pm_target_ms) ? 64'(pm_target_ms) : 64'(pm_elapsed);
		v = el * 64'(pm_flow) / 64'd1000;
		if (v > 64'(pm_target_vol))
			v = 64'(pm_target_vol);
		return v[VOL_W-1:0];
	endfunction

	function automatic void start_run(logic [63:0] ms, logic [VOL_W-1:0] vol);
		if (ms > 64'(MAX_RUN_MS))
			ms = 64'(MAX_RUN_MS);
		pm_target_ms  = ms[MS_W-1:0];
		pm_target_vol = vol;
		pm_delivered  = '0;
		pm_elapsed    = '0;
		pm_running    = 1'b1;
	endfunction

	function automatic void halt_run();
		if (pm_running)
			pm_delivered = live_volume();
		pm_running = 1'b0;
	endfunction

	function automatic pump_status_t pump_step(func_t f, logic [VOL_W-1:0] dv,
		logic [MS_W-1:0] rd);
		pump_status_t s;
		logic [63:0]  wide;
		s = '0;
		case (f)
			FUNC_TICK: begin
				if (pm_running) begin
					if (pm_elapsed != MS_SAT)
						pm_elapsed++;
					if (pm_elapsed >= pm_target_ms) begin
						halt_run();
						s.run_finished = 1'b1;
					end
				end
			end
			FUNC_DOSE: begin
				if (!pm_running && dv != '0 && pm_flow != '0) begin
					wide = 64'(dv) * 64'd1000 / 64'(pm_flow);
					if (wide < 64'(MIN_DOSE_MS))
						wide = 64'(MIN_DOSE_MS);
					start_run(wide, dv);
					s.start_accepted = 1'b1;
				end
			end
			FUNC_TIMED: begin
				if (!pm_running && rd != '0) begin
					wide = 64'(rd) * 64'(pm_flow) / 64'd1000;
					if (wide > 64'(VOL_SAT))
						wide = 64'(VOL_SAT);
					start_run(64'(rd), wide[VOL_W-1:0]);
					s.start_accepted = 1'b1;
				end
			end
			default: begin
				halt_run();
			end
		endcase
		s.relay_level  = pm_running ? pm_active_high : !pm_active_high;
		s.pump_running = pm_running;
		s.volume_done  = pm_running ? live_volume() : pm_delivered;
		s.run_seconds  = pm_running ? SEC_W'(pm_elapsed / 1000) : '0;
		return s;
	endfunction

	function automatic pump_status_t status_of(logic relay, logic run, logic acc, logic fin,
		logic [VOL_W-1:0] vol);
		return {relay, run, acc, fin, vol, SEC_W'(0)};
	endfunction

	function automatic plan_row_t mk_cmd(func_t f, logic [VOL_W-1:0] dv, logic [MS_W-1:0] rd,
		logic known, pump_status_t want);
		plan_row_t r;
		r = '0;
		r.kind  = ROW_CMD;
		r.func  = f;
		r.dv    = dv;
		r.rd    = rd;
		r.known = known;
		r.want  = want;
		return r;
	endfunction

	function automatic plan_row_t mk_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx  = idx;
		r.data = data;
		return r;
	endfunction

	function automatic logic [VOL_W-1:0] field_value();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return VOL_SAT;
			2: return VOL_W'($urandom_range(1, 50));
			default: return VOL_W'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string what, pump_status_t want, pump_status_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("[%0t] %s: want relay=%0b run=%0b acc=%0b fin=%0b vol=%0d sec=%0d",
				$time, what, want.relay_level, want.pump_running, want.start_accepted,
				want.run_finished, want.volume_done, want.run_seconds);
			$display("    got relay=%0b run=%0b acc=%0b fin=%0b vol=%0d sec=%0d",
				got.relay_level, got.pump_running, got.start_accepted, got.run_finished,
				got.volume_done, got.run_seconds);
		end
	endtask

	task automatic send_word(func_t f, logic [VOL_W-1:0] dv, logic [MS_W-1:0] rd,
		logic known, pump_status_t want);
		pump_status_t pred;
		logic         ignored;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			cmd_if.valid = 1'b0;
			@(negedge clk);
		end
		cmd_if.valid        = 1'b1;
		cmd_if.func         = f;
		cmd_if.dose_volume  = dv;
		cmd_if.run_duration = rd;
		do
			@(posedge clk);
		while (!cmd_if.ready);
		ignored = (f == FUNC_TICK) && !pm_running;
		pred = pump_step(f, dv, rd);
		pending_status.push_back(known ? want : pred);
		if (!ignored)
			words_sent++;
		starts_taken += 32'(pred.start_accepted);
		runs_ended   += 32'(pred.run_finished);
	endtask

	task automatic issue(func_t f, logic [VOL_W-1:0] dv, logic [MS_W-1:0] rd);
		send_word(f, dv, rd, 1'b0, '0);
	endtask

	task automatic settle();
		@(negedge clk);
		cmd_if.valid = 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_FLOW_RATE)
			pm_flow = data;
		else
			pm_active_high = data[0];
	endtask

	task automatic apply_setting(logic [FLOW_W-1:0] flow, logic ah);
		if (pm_running)
			issue(FUNC_STOP, field_value(), field_value());
		settle();
		write_reg(REG_FLOW_RATE, flow);
		write_reg(REG_RELAY_ACTIVE_HIGH, CFG_DATA_W'(ah));
		settings_used++;
	endtask

	task automatic run_ticks(int unsigned n);
		for (int unsigned k = 0; k < n && pm_running; k++)
			issue(FUNC_TICK, field_value(), field_value());
	endtask

	task automatic random_sequence();
		int unsigned      pick;
		logic [MS_W-1:0]  dur;
		logic [VOL_W-1:0] vol;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			if ($urandom_range(0, 9) == 0)
				dur = MS_W'($urandom);
			else
				dur = MS_W'($urandom_range(1, 40));
			issue(FUNC_TIMED, field_value(), dur);
			run_ticks($urandom_range(0, 45));
			if (pm_running && $urandom_range(0, 3) != 0)
				issue(FUNC_STOP, field_value(), field_value());
		end else if (pick < 70) begin
			if ($urandom_range(0, 1) == 0)
				vol = VOL_W'($urandom_range(1, pm_flow / 5 + 1));
			else
				vol = field_value();
			issue(FUNC_DOSE, vol, field_value());
			if (pm_running && pm_target_ms <= 210 && $urandom_range(0, 3) == 0)
				run_ticks(32'(pm_target_ms));
			else
				run_ticks($urandom_range(0, 20));
			if (pm_running && $urandom_range(0, 3) != 0)
				issue(FUNC_STOP, field_value(), field_value());
		end else begin
			repeat ($urandom_range(1, 6))
				issue(func_t'($urandom_range(0, 3)), field_value(), field_value());
		end
	endtask

	always @(negedge clk)
		rsp_if.ready = ($urandom_range(0, 99) >= sink_idle_pct);

	always @(posedge clk) begin
		pump_status_t got;
		pump_status_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = {rsp_if.relay_level, rsp_if.pump_running, rsp_if.start_accepted,
				rsp_if.run_finished, rsp_if.volume_done, rsp_if.run_seconds};
			if (pending_status.size() == 0) begin
				report_mismatch("unexpected word", '0, got);
			end else begin
				want = pending_status.pop_front();
				if (got !== want)
					report_mismatch("word mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words outstanding", cycles,
				pending_status.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [FLOW_W-1:0] flow;
		logic              ah;
		int unsigned       quota;

		cmd_if.valid        = 1'b0;
		cmd_if.func         = FUNC_TICK;
		cmd_if.dose_volume  = '0;
		cmd_if.run_duration = '0;
		rsp_if.ready        = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;
		arst_n              = 1'b0;

		pm_running     = 1'b0;
		pm_elapsed     = '0;
		pm_target_ms   = '0;
		pm_target_vol  = '0;
		pm_delivered   = '0;
		pm_flow        = '0;
		pm_active_high = 1'b0;

		// reset registers: zero flow, relay active low
		plan_rows.push_back(mk_cmd(FUNC_TICK, '0, '0, 1'b1, status_of(1, 0, 0, 0, 0)));
		plan_rows.push_back(mk_cmd(FUNC_STOP, VOL_SAT, MS_SAT, 1'b1, status_of(1, 0, 0, 0, 0)));
		plan_rows.push_back(mk_cmd(FUNC_DOSE, 24'd1000, '0, 1'b1, status_of(1, 0, 0, 0, 0)));
		plan_rows.push_back(mk_cmd(FUNC_TIMED, '0, 24'd3, 1'b1, status_of(0, 1, 1, 0, 0)));
		plan_rows.push_back(mk_cmd(FUNC_TIMED, '0, 24'd7, 1'b1, status_of(0, 1, 0, 0, 0)));
		plan_rows.push_back(mk_cmd(FUNC_TICK, '0, '0, 1'b0, '0));
		plan_rows.push_back(mk_cmd(FUNC_STOP, '0, '0, 1'b1, status_of(1, 0, 0, 0, 0)));
		plan_rows.push_back(mk_cfg(REG_FLOW_RATE, 20'd1000000));
		plan_rows.push_back(mk_cfg(REG_RELAY_ACTIVE_HIGH, 20'd1));
		plan_rows.push_back(mk_cmd(FUNC_DOSE, '0, MS_SAT, 1'b1, status_of(0, 0, 0, 0, 0)));
		plan_rows.push_back(mk_cmd(FUNC_TIMED, VOL_SAT, '0, 1'b1, status_of(0, 0, 0, 0, 0)));
		plan_rows.push_back(mk_cmd(FUNC_DOSE, VOL_SAT, '0, 1'b1, status_of(1, 1, 1, 0, 0)));
		plan_rows.push_back(mk_cmd(FUNC_DOSE, 24'd5, '0, 1'b1, status_of(1, 1, 0, 0, 0)));
		plan_rows.push_back(mk_cmd(FUNC_TICK, '0, '0, 1'b0, '0));
		plan_rows.push_back(mk_cmd(FUNC_TICK, VOL_SAT, MS_SAT, 1'b0, '0));
		plan_rows.push_back(mk_cmd(FUNC_STOP, '0, '0, 1'b0, '0));
		// saturating target volume, duration clamped
		plan_rows.push_back(mk_cmd(FUNC_TIMED, '0, MS_SAT, 1'b1, status_of(1, 1, 1, 0, 0)));
		plan_rows.push_back(mk_cmd(FUNC_TICK, '0, '0, 1'b0, '0));
		plan_rows.push_back(mk_cmd(FUNC_STOP, '0, '0, 1'b0, '0));
		plan_rows.push_back(mk_cfg(REG_FLOW_RATE, 20'd1));
		plan_rows.push_back(mk_cmd(FUNC_DOSE, VOL_SAT, '0, 1'b1, status_of(1, 1, 1, 0, 0)));
		plan_rows.push_back(mk_cmd(FUNC_STOP, '0, '0, 1'b1, status_of(0, 0, 0, 0, 0)));
		plan_rows.push_back(mk_cfg(REG_FLOW_RATE, 20'd1000));
		plan_rows.push_back(mk_cmd(FUNC_TIMED, '0, 24'd2, 1'b1, status_of(1, 1, 1, 0, 0)));
		plan_rows.push_back(mk_cmd(FUNC_TICK, '0, '0, 1'b0, '0));
		plan_rows.push_back(mk_cmd(FUNC_TICK, '0, '0, 1'b0, '0));
		plan_rows.push_back(mk_cmd(FUNC_TICK, '0, '0, 1'b1, status_of(0, 0, 0, 0, 24'd2)));
		plan_rows.push_back(mk_cmd(FUNC_STOP, '0, '0, 1'b1, status_of(0, 0, 0, 0, 24'd2)));
		plan_rows.push_back(mk_cfg(REG_RELAY_ACTIVE_HIGH, 20'd0));
		plan_rows.push_back(mk_cmd(FUNC_TICK, '0, '0, 1'b1, status_of(1, 0, 0, 0, 24'd2)));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan_rows[i]) begin
			if (plan_rows[i].kind == ROW_CFG) begin
				settle();
				write_reg(plan_rows[i].idx, plan_rows[i].data);
			end else begin
				send_word(plan_rows[i].func, plan_rows[i].dv, plan_rows[i].rd,
					plan_rows[i].known, plan_rows[i].want);
			end
		end

		for (int p = 0; p < 6; p++) begin
			if (p < 2) begin
				src_idle_pct  = 19;
				sink_idle_pct = 80;
			end else if (p < 4) begin
				src_idle_pct  = 80;
				sink_idle_pct = 19;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			case (p)
				0: begin
					flow = 20'd1000;
					ah   = 1'b0;
				end
				1: begin
					flow = FLOW_W'($urandom_range(1, 1000000));
					ah   = 1'b1;
				end
				2: begin
					flow = 20'd1000000;
					ah   = 1'b1;
				end
				3: begin
					flow = '0;
					ah   = 1'b0;
				end
				4: begin
					flow = 20'd1;
					ah   = 1'b1;
				end
				default: begin
					flow = FLOW_W'($urandom_range(0, 1000000));
					ah   = 1'b0;
				end
			endcase
			apply_setting(flow, ah);
			quota = words_sent + PHASE_WORDS;
			while (words_sent < quota)
				random_sequence();
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d active command words over %0d register settings in %0d cycles",
			words_sent, settings_used, cycles);
		$display("Runs started: %0d, runs ended at target: %0d, mismatches: %0d",
			starts_taken, runs_ended, mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/dprt_pkg.sv
hw/rtl/dprt_if.sv
hw/rtl/dprt_div.sv
hw/rtl/dprt_ctrl.sv
hw/rtl/dprt_dp.sv
hw/rtl/dosing_pump_run_timer.sv
bench/testbench.sv
